// ===== rtl/binary_rate_flow_control_macros.svh =====
// Assertion macros shared by the flow control RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef BINARY_RATE_FLOW_CONTROL_MACROS_SVH
`define BINARY_RATE_FLOW_CONTROL_MACROS_SVH

// Same-cycle implication, checked out of reset
`define BRFC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define BRFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/brfc_pkg.sv =====
// Types and constants for the binary rate flow control block.
// No dependencies; used by every RTL file through scoped names.
package brfc_pkg;

	// Fixed time constants, milliseconds
	localparam logic [15:0] PENALTY_RESET = 16'd4000;
	localparam logic [15:0] PENALTY_CAP   = 16'd60000;
	localparam logic [15:0] PENALTY_FLOOR = 16'd1000;
	localparam logic [23:0] WINDOW_MS     = 24'd10000;
	localparam logic [23:0] ACC_MAX       = 24'hFFFFFF;

	// Configuration reset values
	localparam logic [15:0] RTT_THRESHOLD_RESET = 16'd400;
	localparam logic [7:0]  GOOD_RATE_RESET     = 8'd30;
	localparam logic [7:0]  BAD_RATE_RESET      = 8'd10;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_RTT_THRESHOLD = 2'd0,
		REG_GOOD_RATE     = 2'd1,
		REG_BAD_RATE      = 2'd2
	} reg_idx_t;

	// Event codes reported with each result
	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_DROP       = 3'd1,
		EV_DROP_RAISE = 3'd2,
		EV_REDUCE     = 3'd3,
		EV_UPGRADE    = 3'd4
	} ev_t;

	typedef struct packed {
		logic [15:0] elapsed_ms;
		logic [15:0] rtt_ms;
	} in_t;

	typedef struct packed {
		logic        good_mode;
		logic [7:0]  send_rate;
		logic [15:0] penalty_ms;
		logic [2:0]  event_res;
	} out_t;

	typedef struct packed {
		logic [15:0] rtt_threshold_ms;
		logic [7:0]  good_send_rate;
		logic [7:0]  bad_send_rate;
	} cfg_t;

	typedef struct packed {
		logic        mode_good;
		logic [15:0] penalty_time;
		logic [23:0] good_time;
		logic [23:0] reduction_time;
	} state_t;

endpackage

// ===== rtl/brfc_cfg.sv =====
// Configuration register file for the flow control block.
// Depends on brfc_pkg for register indexes, reset values and cfg_t.
module brfc_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [1:0]          wr_index,
	input  logic [15:0]         wr_data,
	output brfc_pkg::cfg_t      cfg
);

	brfc_pkg::cfg_t cfg_q;

	// Write the addressed register; drop writes to unused indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rtt_threshold_ms <= brfc_pkg::RTT_THRESHOLD_RESET;
			cfg_q.good_send_rate   <= brfc_pkg::GOOD_RATE_RESET;
			cfg_q.bad_send_rate    <= brfc_pkg::BAD_RATE_RESET;
		end else if (wr_en) begin
			if (wr_index == brfc_pkg::REG_RTT_THRESHOLD) begin
				cfg_q.rtt_threshold_ms <= wr_data;
			end
			if (wr_index == brfc_pkg::REG_GOOD_RATE) begin
				cfg_q.good_send_rate <= wr_data[7:0];
			end
			if (wr_index == brfc_pkg::REG_BAD_RATE) begin
				cfg_q.bad_send_rate <= wr_data[7:0];
			end
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/brfc_step.sv =====
// One-tick update of the good/bad mode, penalty and accumulators.
// Purely combinational; depends on brfc_pkg for types and constants.
module brfc_step (
	input  brfc_pkg::state_t st,
	input  brfc_pkg::in_t    item,
	input  brfc_pkg::cfg_t   cfg,
	output brfc_pkg::state_t nxt,
	output brfc_pkg::out_t   res
);

	logic        bad_rtt;
	logic [24:0] gt_sum;
	logic [24:0] rt_sum;
	logic [23:0] gt_add;
	logic [23:0] rt_add;
	logic [16:0] pen_dbl;
	logic [15:0] pen_raise;
	logic [15:0] pen_half;
	logic [15:0] pen_red;
	logic [23:0] gt_bad;
	brfc_pkg::ev_t ev;

	assign bad_rtt = item.rtt_ms > cfg.rtt_threshold_ms;

	// Saturating accumulator adds
	assign gt_sum = {1'b0, st.good_time} + {9'b0, item.elapsed_ms};
	assign rt_sum = {1'b0, st.reduction_time} + {9'b0, item.elapsed_ms};
	assign gt_add = gt_sum[24] ? brfc_pkg::ACC_MAX : gt_sum[23:0];
	assign rt_add = rt_sum[24] ? brfc_pkg::ACC_MAX : rt_sum[23:0];

	// Penalty raise with cap, reduction with floor
	assign pen_dbl   = {st.penalty_time, 1'b0};
	assign pen_raise = (pen_dbl > {1'b0, brfc_pkg::PENALTY_CAP}) ?
		brfc_pkg::PENALTY_CAP : pen_dbl[15:0];
	assign pen_half  = {1'b0, st.penalty_time[15:1]};
	assign pen_red   = (pen_half < brfc_pkg::PENALTY_FLOOR) ?
		brfc_pkg::PENALTY_FLOOR : pen_half;

	assign gt_bad = bad_rtt ? 24'd0 : gt_add;

	// Next state and event
	always_comb begin
		nxt = st;
		ev  = brfc_pkg::EV_NONE;
		if (st.mode_good) begin
			if (bad_rtt) begin
				nxt.mode_good      = 1'b0;
				nxt.good_time      = 24'd0;
				nxt.reduction_time = 24'd0;
				ev                 = brfc_pkg::EV_DROP;
				if (st.good_time < brfc_pkg::WINDOW_MS &&
						st.penalty_time < brfc_pkg::PENALTY_CAP) begin
					nxt.penalty_time = pen_raise;
					ev               = brfc_pkg::EV_DROP_RAISE;
				end
			end else begin
				nxt.good_time      = gt_add;
				nxt.reduction_time = rt_add;
				if (rt_add > brfc_pkg::WINDOW_MS &&
						st.penalty_time > brfc_pkg::PENALTY_FLOOR) begin
					nxt.penalty_time   = pen_red;
					nxt.reduction_time = 24'd0;
					ev                 = brfc_pkg::EV_REDUCE;
				end
			end
		end else begin
			nxt.good_time = gt_bad;
			if (gt_bad > {8'd0, st.penalty_time}) begin
				nxt.mode_good      = 1'b1;
				nxt.good_time      = 24'd0;
				nxt.reduction_time = 24'd0;
				ev                 = brfc_pkg::EV_UPGRADE;
			end
		end
	end

	// Result fields from the state after this tick
	always_comb begin
		res.good_mode  = nxt.mode_good;
		res.send_rate  = nxt.mode_good ? cfg.good_send_rate : cfg.bad_send_rate;
		res.penalty_ms = nxt.penalty_time;
		res.event_res  = ev;
	end

endmodule

// ===== rtl/binary_rate_flow_control.sv =====
// Binary good/bad mode flow control. Each input transfer is one tick (elapsed
// time and measured round-trip time in ms) and yields exactly one result
// transfer with mode, send rate, penalty and event code. A tick is captured
// in an input register, the whole mode/penalty/accumulator update is done in
// one combinational pass, and the result lands in an output register: one
// tick per clock sustained while out_stall is low. The result is valid once it
// lands in the output register and transfers from there when out_stall is low.
// While a result waits in the output register the input register can still
// take one tick; in_stall then holds off further ticks until the result
// transfers. Configuration writes are taken every cycle (ready held high).
// Depends on brfc_pkg, brfc_cfg, brfc_step and the macros header.
`include "binary_rate_flow_control_macros.svh"

module binary_rate_flow_control (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  brfc_pkg::in_t     in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output brfc_pkg::out_t    out_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	brfc_pkg::cfg_t   cfg;
	brfc_pkg::state_t st_q;
	brfc_pkg::state_t st_nxt;
	brfc_pkg::out_t   res;

	logic            in_valid_s1;
	brfc_pkg::in_t   in_item_s1;
	logic            out_valid_s2;
	brfc_pkg::out_t  out_item_s2;

	logic out_free;
	logic s1_adv;
	logic in_take;

	assign cfg_ready = 1'b1;

	brfc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	brfc_step u_step (
		.st   (st_q),
		.item (in_item_s1),
		.cfg  (cfg),
		.nxt  (st_nxt),
		.res  (res)
	);

	// Pipeline handshake
	assign out_free = !out_valid_s2 || !out_stall;
	assign s1_adv   = in_valid_s1 && out_free;
	assign in_stall = in_valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_take) begin
			in_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			in_valid_s1 <= 1'b0;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			in_item_s1 <= in_item;
		end
	end

	// Advance the flow control state once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode_good      <= 1'b0;
			st_q.penalty_time   <= brfc_pkg::PENALTY_RESET;
			st_q.good_time      <= 24'd0;
			st_q.reduction_time <= 24'd0;
		end else if (s1_adv) begin
			st_q <= st_nxt;
		end
	end

	// Result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_item_s2 <= res;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_item  = out_item_s2;

	// Checks
	`BRFC_ASSERT_NOW(a_penalty_range, 1'b1,
		st_q.penalty_time >= brfc_pkg::PENALTY_FLOOR &&
		st_q.penalty_time <= brfc_pkg::PENALTY_CAP, "penalty out of range")
	`BRFC_ASSERT_NEXT(a_s1_hold, in_valid_s1 && !out_free,
		in_valid_s1 && $stable(in_item_s1), "input stage lost a held tick")
	`BRFC_ASSERT_NEXT(a_state_hold, !s1_adv, $stable(st_q),
		"state changed without a processed tick")
	`BRFC_ASSERT_NOW(a_upgrade_mode,
		out_valid_s2 && out_item_s2.event_res == brfc_pkg::EV_UPGRADE,
		out_item_s2.good_mode, "upgrade event without good mode")
	`BRFC_ASSERT_NOW(a_drop_mode,
		out_valid_s2 && (out_item_s2.event_res == brfc_pkg::EV_DROP ||
		out_item_s2.event_res == brfc_pkg::EV_DROP_RAISE),
		!out_item_s2.good_mode, "drop event while in good mode")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for binary_rate_flow_control: ticks go in, mode/rate/penalty reports
// come out and are compared with an in-bench model of the good/bad link logic.
// Depends on brfc_pkg and the binary_rate_flow_control RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Index past the register file; writes to it must be dropped
	localparam logic [1:0] REG_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	brfc_pkg::in_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	brfc_pkg::out_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	binary_rate_flow_control uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Model of the link: configuration and state
	logic [15:0] link_thr = brfc_pkg::RTT_THRESHOLD_RESET;
	logic [7:0] rate_good = brfc_pkg::GOOD_RATE_RESET;
	logic [7:0] rate_bad = brfc_pkg::BAD_RATE_RESET;
	logic link_good = 1'b0;
	logic [15:0] link_penalty = brfc_pkg::PENALTY_RESET;
	logic [23:0] good_ms = '0;
	logic [23:0] reduce_ms = '0;

	brfc_pkg::in_t tick_queue[$];
	brfc_pkg::out_t expected_reports[$];
	logic in_taken = 1'b0;
	logic cfg_done = 1'b0;
	logic calm_traffic = 1'b0;
	int mismatch_count = 0;
	int send_gap = 0;
	int stall_left = 0;

	function automatic logic [23:0] sat_ms(logic [23:0] acc, logic [15:0] inc);
		logic [24:0] s;
		s = {1'b0, acc} + {9'b0, inc};
		return (s > {1'b0, brfc_pkg::ACC_MAX}) ? brfc_pkg::ACC_MAX : s[23:0];
	endfunction

	// Advance the link model by one tick and build the report it yields
	function automatic brfc_pkg::out_t advance_link(brfc_pkg::in_t t);
		logic bad_rtt;
		logic [16:0] dbl;
		brfc_pkg::ev_t ev;
		brfc_pkg::out_t r;
		bad_rtt = t.rtt_ms > link_thr;
		ev = brfc_pkg::EV_NONE;
		if (link_good) begin
			if (bad_rtt) begin
				link_good = 1'b0;
				ev = brfc_pkg::EV_DROP;
				if (good_ms < brfc_pkg::WINDOW_MS && link_penalty < brfc_pkg::PENALTY_CAP) begin
					dbl = {link_penalty, 1'b0};
					link_penalty = (dbl > {1'b0, brfc_pkg::PENALTY_CAP}) ?
						brfc_pkg::PENALTY_CAP : dbl[15:0];
					ev = brfc_pkg::EV_DROP_RAISE;
				end
				good_ms = '0;
				reduce_ms = '0;
			end else begin
				good_ms = sat_ms(good_ms, t.elapsed_ms);
				reduce_ms = sat_ms(reduce_ms, t.elapsed_ms);
				if (reduce_ms > brfc_pkg::WINDOW_MS
						&& link_penalty > brfc_pkg::PENALTY_FLOOR) begin
					link_penalty = link_penalty >> 1;
					if (link_penalty < brfc_pkg::PENALTY_FLOOR)
						link_penalty = brfc_pkg::PENALTY_FLOOR;
					reduce_ms = '0;
					ev = brfc_pkg::EV_REDUCE;
				end
			end
		end else begin
			if (bad_rtt)
				good_ms = '0;
			else
				good_ms = sat_ms(good_ms, t.elapsed_ms);
			if (good_ms > {8'd0, link_penalty}) begin
				good_ms = '0;
				reduce_ms = '0;
				link_good = 1'b1;
				ev = brfc_pkg::EV_UPGRADE;
			end
		end
		r.good_mode = link_good;
		r.send_rate = link_good ? rate_good : rate_bad;
		r.penalty_ms = link_penalty;
		r.event_res = ev;
		return r;
	endfunction

	// Track transfers, update the model and check reports
	always @(posedge clk) begin
		brfc_pkg::out_t want;
		in_taken <= in_valid && !in_stall;
		cfg_done <= cfg_valid && cfg_ready;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				brfc_pkg::REG_RTT_THRESHOLD: link_thr = cfg_data;
				brfc_pkg::REG_GOOD_RATE: rate_good = cfg_data[7:0];
				brfc_pkg::REG_BAD_RATE: rate_bad = cfg_data[7:0];
				default: ;
			endcase
		end
		if (in_valid && !in_stall)
			expected_reports.push_back(advance_link(in_item));
		if (out_valid && !out_stall) begin
			if (expected_reports.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected report: mode=%0d rate=%0d penalty=%0d event=%0d",
						out_item.good_mode, out_item.send_rate, out_item.penalty_ms,
						out_item.event_res);
			end else begin
				want = expected_reports.pop_front();
				if (out_item.good_mode !== want.good_mode
						|| out_item.send_rate !== want.send_rate
						|| out_item.penalty_ms !== want.penalty_ms
						|| out_item.event_res !== want.event_res) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"report mismatch: expected mode=%0d rate=%0d penalty=%0d ",
							"event=%0d, got mode=%0d rate=%0d penalty=%0d event=%0d"},
							want.good_mode, want.send_rate, want.penalty_ms, want.event_res,
							out_item.good_mode, out_item.send_rate, out_item.penalty_ms,
							out_item.event_res);
				end
			end
		end
	end

	// Tick driver: hold until transfer, then advance or pause for a burst
	always @(negedge clk) begin
		if (in_valid && !in_taken) begin
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap--;
		end else if (tick_queue.size() != 0) begin
			in_valid <= 1'b1;
			in_item <= tick_queue.pop_front();
			if (!calm_traffic && $urandom_range(0, 11) == 0)
				send_gap = $urandom_range(1, 19);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Report receiver: stall in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			if (!calm_traffic && $urandom_range(0, 13) == 0)
				stall_left = $urandom_range(1, 19);
		end
	end

	task automatic queue_tick(input logic [15:0] el, input logic [15:0] rt);
		brfc_pkg::in_t t;
		t.elapsed_ms = el;
		t.rtt_ms = rt;
		tick_queue.push_back(t);
	endtask

	// RTT on the chosen side of the current threshold
	function automatic logic [15:0] pick_rtt(bit want_bad);
		logic [15:0] v;
		if (want_bad && link_thr != 16'hFFFF)
			v = 16'($urandom_range(32'(link_thr) + 1, 65535));
		else if (want_bad)
			v = 16'hFFFF;
		else
			v = 16'($urandom_range(0, 32'(link_thr)));
		return v;
	endfunction

	function automatic logic [15:0] pick_elapsed(int unsigned hi);
		logic [15:0] v;
		case ($urandom_range(0, 9))
			0: v = 16'hFFFF;
			1: v = 16'($urandom);
			default: v = 16'($urandom_range(0, hi));
		endcase
		return v;
	endfunction

	// Mostly well-formed good/bad stretches, some pure noise
	task automatic queue_random(int n);
		int kind;
		int len;
		int k;
		while (n > 0) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				len = $urandom_range(3, 15);
				for (k = 0; k < len; k++)
					queue_tick(pick_elapsed(20000), pick_rtt(1'b0));
			end else if (kind < 65) begin
				len = $urandom_range(1, 2);
				for (k = 0; k < len; k++)
					queue_tick(pick_elapsed(3000), pick_rtt(1'b1));
			end else if (kind < 80) begin
				len = $urandom_range(10, 40);
				for (k = 0; k < len; k++)
					queue_tick(pick_elapsed(600), pick_rtt($urandom_range(0, 19) == 0));
			end else begin
				len = $urandom_range(1, 6);
				for (k = 0; k < len; k++)
					queue_tick(16'($urandom), 16'($urandom));
			end
			n -= len;
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(negedge clk); while (!cfg_done);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (tick_queue.size() != 0 || in_valid
			|| expected_reports.size() != 0);
	endtask

	// Stimulus phases
	initial begin
		int k;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: walk the penalty up to the cap, then down to the floor
		queue_tick(16'd0, 16'd0);
		queue_tick(16'hFFFF, 16'd400);
		queue_tick(16'd0, 16'd401);
		for (k = 0; k < 4; k++) begin
			queue_tick(16'hFFFF, 16'd0);
			queue_tick(16'd100, 16'hFFFF);
		end
		queue_tick(16'hFFFF, 16'd0);
		queue_tick(16'd10001, 16'd0);
		for (k = 0; k < 6; k++)
			queue_tick(16'hFFFF, 16'd0);
		queue_tick(16'd0, 16'hFFFF);
		queue_tick(16'd1000, 16'd0);
		queue_tick(16'd1, 16'd0);
		queue_tick(16'd5000, 16'd0);
		queue_tick(16'd6000, 16'd0);
		queue_random(150);
		wait_drained();

		// Threshold at zero, rates at opposite extremes, stray index
		write_reg(brfc_pkg::REG_RTT_THRESHOLD, 16'd0);
		write_reg(brfc_pkg::REG_GOOD_RATE, {8'($urandom), 8'd255});
		write_reg(brfc_pkg::REG_BAD_RATE, 16'd0);
		write_reg(REG_NONE, 16'($urandom));
		@(posedge clk);
		queue_random(150);
		wait_drained();

		// Threshold at max: every RTT is good, accumulators run to saturation
		write_reg(brfc_pkg::REG_RTT_THRESHOLD, 16'hFFFF);
		write_reg(brfc_pkg::REG_GOOD_RATE, 16'd0);
		write_reg(brfc_pkg::REG_BAD_RATE, {8'($urandom), 8'd255});
		@(posedge clk);
		for (k = 0; k < 280; k++)
			queue_tick(16'hFFFF, 16'($urandom));
		queue_random(40);
		wait_drained();

		write_reg(brfc_pkg::REG_RTT_THRESHOLD, 16'($urandom));
		write_reg(brfc_pkg::REG_GOOD_RATE, 16'($urandom));
		write_reg(brfc_pkg::REG_BAD_RATE, 16'($urandom));
		@(posedge clk);
		queue_random(150);
		wait_drained();

		// Last stretch at full rate on both sides
		write_reg(brfc_pkg::REG_RTT_THRESHOLD, brfc_pkg::RTT_THRESHOLD_RESET);
		write_reg(brfc_pkg::REG_GOOD_RATE, 16'($urandom));
		write_reg(brfc_pkg::REG_BAD_RATE, 16'($urandom));
		@(posedge clk);
		calm_traffic = 1'b1;
		queue_random(150);
		wait_drained();

		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/brfc_pkg.sv
rtl/brfc_cfg.sv
rtl/brfc_step.sv
rtl/binary_rate_flow_control.sv
tb/testbench.sv
